// File: design/gnla_pkg.sv
package gnla_pkg;

    localparam int MAX_LANDMARKS = 64;
    localparam int ADDR_W        = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int COUNT_W       = 7;
    localparam int CNT_W         = ($clog2(MAX_LANDMARKS + 1) > COUNT_W) ?
                                   $clog2(MAX_LANDMARKS + 1) : COUNT_W;
    localparam int COORD_W       = 18;
    localparam int GAP_W         = COORD_W;
    localparam int RANGE_W       = 17;
    localparam int SLOT_W        = 6;
    localparam int IDX_OUT_W     = 6;
    localparam int SQ_W          = 2 * RANGE_W;
    localparam int DIST_W        = SQ_W + 1;
    localparam int CFG_DATA_W    = RANGE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_OBSERVE = 1'b1
    } t_opcode;

    typedef enum logic {
        CFG_SENSOR_RANGE   = 1'b0,
        CFG_LANDMARK_COUNT = 1'b1
    } t_cfg_index;

endpackage

// File: design/gated_nearest_landmark_association.sv
// Gated nearest-landmark association.
// Input channel (i_in_valid / o_in_ready): a load item (opcode 0) writes one landmark into
// the table slot given by i_slot. An observe item (opcode 1) scans landmarks 0 to
// landmark_count-1 and yields one result item on the output channel (o_out_valid /
// i_out_ready): the index of the nearest landmark inside the gating box and a flag that
// tells whether any landmark passed the box.
// The scan reads one table entry per cycle through a five-stage pipeline (table read,
// gaps and gate, squares, sum, best-so-far compare). No new item is accepted until the
// observe item's result has been written to the output register.
// With a landmark count of zero the scan is skipped and the result flags no landmark.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data; the user must
// write it only while the block is idle, which the block itself does not enforce:
// index 0 is the gate half-width, index 1 is the landmark count, which saturates
// at the table depth.
// Reset clears both configuration registers and all control state; table entries hold
// nothing defined until they are loaded. A waiting result sits in the output register
// while new items are accepted; if the receiver still stalls when the next scan ends,
// that scan holds its result until the output register is free.
module gated_nearest_landmark_association
    import gnla_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_opcode,
    input  logic [SLOT_W-1:0]      i_slot,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [IDX_OUT_W-1:0]   o_nearest_index,
    output logic                   o_any_in_range
);

    t_state                     r_state;
    t_state                     n_state;
    logic [RANGE_W-1:0]         r_sensor_range;
    logic [COUNT_W-1:0]         r_landmark_count;

    logic signed [COORD_W-1:0]  r_mem_x [MAX_LANDMARKS];
    logic signed [COORD_W-1:0]  r_mem_y [MAX_LANDMARKS];

    logic signed [COORD_W-1:0]  r_obs_x;
    logic signed [COORD_W-1:0]  r_obs_y;
    logic [CNT_W-1:0]           r_scan_n;
    logic [CNT_W-1:0]           r_idx;

    logic                       r_v1;
    logic [ADDR_W-1:0]          r_idx1;
    logic signed [COORD_W-1:0]  r_rd_x;
    logic signed [COORD_W-1:0]  r_rd_y;

    logic                       r_v2;
    logic [ADDR_W-1:0]          r_idx2;
    logic                       r_pass2;
    logic [RANGE_W-1:0]         r_gx2;
    logic [RANGE_W-1:0]         r_gy2;

    logic                       r_v3;
    logic [ADDR_W-1:0]          r_idx3;
    logic                       r_pass3;
    logic [SQ_W-1:0]            r_sqx3;
    logic [SQ_W-1:0]            r_sqy3;

    logic                       r_v4;
    logic [ADDR_W-1:0]          r_idx4;
    logic                       r_pass4;
    logic [DIST_W-1:0]          r_d4;

    logic                       r_found;
    logic [ADDR_W-1:0]          r_best_idx;
    logic [DIST_W-1:0]          r_best_d;

    logic                       r_out_valid;
    logic [IDX_OUT_W-1:0]       r_out_idx;
    logic                       r_out_any;

    logic                       in_fire;
    logic                       obs_start;
    logic                       issue;
    logic                       finish;
    logic                       pipe_busy;
    logic                       out_free;
    logic [CNT_W-1:0]           count_ext;
    logic [CNT_W-1:0]           count_sat;
    logic signed [COORD_W:0]    dx;
    logic signed [COORD_W:0]    dy;
    logic [GAP_W-1:0]           gx;
    logic [GAP_W-1:0]           gy;
    logic                       gate_ok;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign obs_start   = in_fire && (i_opcode == OP_OBSERVE);
    assign pipe_busy   = r_v1 || r_v2 || r_v3 || r_v4;
    assign out_free    = !r_out_valid || i_out_ready;
    assign count_ext   = CNT_W'(r_landmark_count);
    assign count_sat   = (count_ext > CNT_W'(MAX_LANDMARKS)) ?
                         CNT_W'(MAX_LANDMARKS) : count_ext;

    always_comb begin
        n_state = r_state;
        issue   = 1'b0;
        finish  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (obs_start) begin
                    n_state = (count_sat == '0) ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                issue = 1'b1;
                if (r_idx + CNT_W'(1) == r_scan_n) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!pipe_busy && out_free) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_range   <= '0;
            r_landmark_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SENSOR_RANGE:   r_sensor_range   <= i_cfg_data[RANGE_W-1:0];
                CFG_LANDMARK_COUNT: r_landmark_count <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_opcode == OP_LOAD) &&
            ((CNT_W + SLOT_W)'(i_slot) < (CNT_W + SLOT_W)'(MAX_LANDMARKS))) begin
            r_mem_x[ADDR_W'(i_slot)] <= i_point_x;
            r_mem_y[ADDR_W'(i_slot)] <= i_point_y;
        end
        if (issue) begin
            r_rd_x <= r_mem_x[r_idx[ADDR_W-1:0]];
            r_rd_y <= r_mem_y[r_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (obs_start) begin
            r_obs_x  <= i_point_x;
            r_obs_y  <= i_point_y;
            r_scan_n <= count_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (obs_start) begin
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    always_comb begin
        dx      = (COORD_W+1)'(r_rd_x) - (COORD_W+1)'(r_obs_x);
        dy      = (COORD_W+1)'(r_rd_y) - (COORD_W+1)'(r_obs_y);
        gx      = dx[COORD_W] ? GAP_W'(-dx) : GAP_W'(dx);
        gy      = dy[COORD_W] ? GAP_W'(-dy) : GAP_W'(dy);
        gate_ok = (gx <= GAP_W'(r_sensor_range)) && (gy <= GAP_W'(r_sensor_range));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1  <= r_idx[ADDR_W-1:0];
        r_idx2  <= r_idx1;
        r_pass2 <= gate_ok;
        r_gx2   <= gx[RANGE_W-1:0];
        r_gy2   <= gy[RANGE_W-1:0];
        r_idx3  <= r_idx2;
        r_pass3 <= r_pass2;
        r_sqx3  <= r_gx2 * r_gx2;
        r_sqy3  <= r_gy2 * r_gy2;
        r_idx4  <= r_idx3;
        r_pass4 <= r_pass3;
        r_d4    <= DIST_W'(r_sqx3) + DIST_W'(r_sqy3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (obs_start) begin
            r_found <= 1'b0;
        end else if (r_v4 && r_pass4) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (obs_start) begin
            r_best_idx <= '0;
            r_best_d   <= '0;
        end else if (r_v4 && r_pass4 && (!r_found || (r_d4 < r_best_d))) begin
            r_best_idx <= r_idx4;
            r_best_d   <= r_d4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_idx <= IDX_OUT_W'(r_best_idx);
            r_out_any <= r_found;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_nearest_index = r_out_idx;
    assign o_any_in_range  = r_out_any;

`ifndef SYNTHESIS
    a_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !pipe_busy)
        else $error("scan pipeline holds an entry while the block is idle");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx < r_scan_n))
        else $error("scan index beyond the landmark count");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && !r_found) |=> (o_out_valid && (o_nearest_index == '0)))
        else $error("result without a gated landmark carries a nonzero index");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |-> out_free)
        else $error("result written over a waiting item");
`endif

endmodule
